// ===== rtl/wrc_pkg.sv =====
`default_nettype none

package wrc_pkg;

    // Number of axis fields a sample carries: force x, y, z, torque x, y, z.
    localparam int FIELD_COUNT = 6;

    // Parameter defaults for the top level.
    localparam int AXIS_COUNT_DEF   = 6;
    localparam int SAMPLE_WIDTH_DEF = 32;

    // Fixed-point layout of the filter factor (unsigned Q1.16).
    localparam int FRAC_W   = 16;
    localparam int FACTOR_W = 17;
    localparam logic [FACTOR_W-1:0] FACTOR_ONE = 17'h10000;

    // Deadband thresholds are unsigned Q15.16 magnitudes.
    localparam int DB_W = 31;

    // Configuration port geometry.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 31;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_SMOOTHING = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DB_FX     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DB_FY     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_DB_FZ     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DB_TX     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DB_TY     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DB_TZ     = 3'd6;

    // Reset values of the registers.
    localparam logic [FACTOR_W-1:0] FACTOR_RST = FACTOR_ONE;
    localparam logic [DB_W-1:0] DB_FX_RST = 31'd65536;
    localparam logic [DB_W-1:0] DB_FY_RST = 31'd65536;
    localparam logic [DB_W-1:0] DB_FZ_RST = 31'd0;
    localparam logic [DB_W-1:0] DB_TX_RST = 31'd6554;
    localparam logic [DB_W-1:0] DB_TY_RST = 31'd6554;
    localparam logic [DB_W-1:0] DB_TZ_RST = 31'd6554;

    // Pipeline load strobes shared by every lane.
    typedef struct packed {
        logic tare_load;   // latch this sample as the tare offset
        logic tare_taken;  // tare offset holds a valid sample
        logic load1;       // stage 1 takes a new tared sample
        logic load2;       // stage 2 advances the filter state
        logic load3;       // stage 3 takes a new thresholded result
    } t_pipe_ctl;

endpackage

`default_nettype wire

// ===== rtl/six_axis_wrench_conditioner.sv =====
`default_nettype none

// Six-axis wrench conditioner. Each input transaction carries one
// force/torque sample in signed Q16.16; each output transaction carries the
// conditioned sample. A sample whose force x or force y is zero is consumed
// but produces no output transaction and leaves all state untouched. The
// first sample that passes this check after reset becomes the tare offset,
// so its own output is the filter response to zero. Every passing sample is
// tared with saturation, run through a first-order smoothing filter per axis
// (y += floor(a * (x - y) / 2^16), a from the smoothing register, values
// above 1.0 acting as 1.0), and each axis whose filtered magnitude is below
// its deadband register is reported as zero; the filter keeps the value
// before the deadband. The block accepts one transaction per clock while the
// output is not stalled, passing it through tare, filter and deadband stages.
// That rate is set by the filter state loop in each axis lane: subtract, one
// multiply and an add feed the state register with no register between. A
// stalled output backs up the three stages before the input is stalled.
// Write the configuration registers only while no transaction is in flight.

module six_axis_wrench_conditioner
    import wrc_pkg::*;
#(
    parameter int AXIS_COUNT   = AXIS_COUNT_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,

    input  wire                            i_cfg_we,
    input  wire        [CFG_INDEX_W-1:0]   i_cfg_index,
    input  wire        [CFG_DATA_W-1:0]    i_cfg_data,

    input  wire                            i_valid,
    output logic                           o_stall,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_force_x_in,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_force_y_in,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_force_z_in,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_torque_x_in,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_torque_y_in,
    input  wire signed [SAMPLE_WIDTH-1:0]  i_torque_z_in,

    output logic                           o_valid,
    input  wire                            i_stall,
    output logic signed [SAMPLE_WIDTH-1:0] o_force_x_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_force_y_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_force_z_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_torque_x_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_torque_y_out,
    output logic signed [SAMPLE_WIDTH-1:0] o_torque_z_out
);

    logic [FACTOR_W-1:0] r_factor;
    logic [DB_W-1:0]     r_deadband [FIELD_COUNT];

    logic [FACTOR_W-1:0]           factor_eff;
    logic                          sample_ok;
    t_pipe_ctl                     ctl;
    logic signed [SAMPLE_WIDTH-1:0] samples [FIELD_COUNT];
    logic signed [SAMPLE_WIDTH-1:0] results [FIELD_COUNT];

    // Configuration registers. Indexes past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor      <= FACTOR_RST;
            r_deadband[0] <= DB_FX_RST;
            r_deadband[1] <= DB_FY_RST;
            r_deadband[2] <= DB_FZ_RST;
            r_deadband[3] <= DB_TX_RST;
            r_deadband[4] <= DB_TY_RST;
            r_deadband[5] <= DB_TZ_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_SMOOTHING: r_factor      <= i_cfg_data[FACTOR_W-1:0];
                REG_DB_FX:     r_deadband[0] <= i_cfg_data[DB_W-1:0];
                REG_DB_FY:     r_deadband[1] <= i_cfg_data[DB_W-1:0];
                REG_DB_FZ:     r_deadband[2] <= i_cfg_data[DB_W-1:0];
                REG_DB_TX:     r_deadband[3] <= i_cfg_data[DB_W-1:0];
                REG_DB_TY:     r_deadband[4] <= i_cfg_data[DB_W-1:0];
                REG_DB_TZ:     r_deadband[5] <= i_cfg_data[DB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Any factor with the unit bit set behaves as exactly one.
    assign factor_eff = r_factor[FACTOR_W-1] ? FACTOR_ONE : r_factor;

    // Samples with a zero force x or force y are dropped at the input.
    assign sample_ok = (i_force_x_in != '0) && (i_force_y_in != '0);

    assign samples[0] = i_force_x_in;
    assign samples[1] = i_force_y_in;
    assign samples[2] = i_force_z_in;
    assign samples[3] = i_torque_x_in;
    assign samples[4] = i_torque_y_in;
    assign samples[5] = i_torque_z_in;

    wrc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_sample_ok (sample_ok),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_ctl       (ctl)
    );

    // One lane per configured axis; the remaining fields read as zero.
    for (genvar g = 0; g < FIELD_COUNT; g++) begin : g_axis
        if (g < AXIS_COUNT) begin : g_lane
            wrc_lane #(
                .SAMPLE_WIDTH (SAMPLE_WIDTH)
            ) u_lane (
                .i_clk      (i_clk),
                .i_rst_n    (i_rst_n),
                .i_ctl      (ctl),
                .i_sample   (samples[g]),
                .i_factor   (factor_eff),
                .i_deadband (r_deadband[g]),
                .o_result   (results[g])
            );
        end else begin : g_unused
            assign results[g] = '0;
        end
    end

    // Merge the lane results into the output transaction.
    assign o_force_x_out  = results[0];
    assign o_force_y_out  = results[1];
    assign o_force_z_out  = results[2];
    assign o_torque_x_out = results[3];
    assign o_torque_y_out = results[4];
    assign o_torque_z_out = results[5];

endmodule

`default_nettype wire

// ===== rtl/wrc_lane.sv =====
`default_nettype none

module wrc_lane
    import wrc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire t_pipe_ctl                i_ctl,
    input  wire signed [SAMPLE_WIDTH-1:0] i_sample,
    input  wire        [FACTOR_W-1:0]     i_factor,
    input  wire        [DB_W-1:0]         i_deadband,
    output logic signed [SAMPLE_WIDTH-1:0] o_result
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int PW    = SW + FACTOR_W + 2;
    localparam int CMP_W = (SW > DB_W) ? SW : DB_W;

    logic signed [SW-1:0] r_tare;
    logic signed [SW-1:0] r_v;
    logic signed [SW-1:0] r_y;
    logic signed [SW-1:0] r_out;

    logic signed [SW:0]   diff;
    logic signed [SW-1:0] sat;
    logic signed [SW-1:0] n_v;
    logic signed [SW:0]   delta;
    logic signed [PW-1:0] prod;
    logic signed [SW-1:0] n_y;
    logic        [SW-1:0] mag;
    logic                 below;
    logic signed [SW-1:0] n_out;

    // Stage 1: remove the tare offset, saturating to the sample range.
    always_comb begin
        diff = {i_sample[SW-1], i_sample} - {r_tare[SW-1], r_tare};
        if (diff[SW] != diff[SW-1]) begin
            sat = diff[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
        end else begin
            sat = diff[SW-1:0];
        end
        // The sample that sets the tare cancels against itself.
        n_v = i_ctl.tare_taken ? sat : '0;
    end

    // Stage 2: y += floor(a * (v - y) / 2^16). The new value lies between
    // the old state and the input, so the low bits of the sum are exact.
    always_comb begin
        delta = {r_v[SW-1], r_v} - {r_y[SW-1], r_y};
        prod  = PW'(delta) * PW'($signed({1'b0, i_factor}));
        n_y   = r_y + prod[FRAC_W+SW-1:FRAC_W];
    end

    // Stage 3: deadband on the magnitude; the most negative value is exact.
    always_comb begin
        mag   = r_y[SW-1] ? (~r_y + 1'b1) : r_y;
        below = CMP_W'(mag) < CMP_W'(i_deadband);
        n_out = below ? '0 : r_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.tare_load) begin
            r_tare <= i_sample;
        end
        if (i_ctl.load1) begin
            r_v <= n_v;
        end
        if (i_ctl.load3) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y <= '0;
        end else if (i_ctl.load2) begin
            r_y <= n_y;
        end
    end

    assign o_result = r_out;

endmodule

`default_nettype wire

// ===== rtl/wrc_ctrl.sv =====
`default_nettype none

module wrc_ctrl
    import wrc_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    input  wire        i_sample_ok,
    output logic       o_stall,
    output logic       o_valid,
    input  wire        i_stall,
    output t_pipe_ctl  o_ctl
);

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_tare_taken;

    logic en1;
    logic en2;
    logic en3;
    logic accept_ok;

    always_comb begin
        en3       = !r_v3 || !i_stall;
        en2       = !r_v2 || en3;
        en1       = !r_v1 || en2;
        accept_ok = i_valid && en1 && i_sample_ok;

        o_ctl.load1      = accept_ok;
        o_ctl.load2      = en2 && r_v1;
        o_ctl.load3      = en3 && r_v2;
        o_ctl.tare_load  = accept_ok && !r_tare_taken;
        o_ctl.tare_taken = r_tare_taken;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
            r_v3         <= 1'b0;
            r_tare_taken <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= accept_ok;
            end
            if (en2) begin
                r_v2 <= r_v1;
            end
            if (en3) begin
                r_v3 <= r_v2;
            end
            if (accept_ok) begin
                r_tare_taken <= 1'b1;
            end
        end
    end

    assign o_stall = !en1;
    assign o_valid = r_v3;

    // A held result is never overwritten while the consumer stalls.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && i_stall) |-> !o_ctl.load3)
        else $error("output stage overwritten while stalled");

    // The filter state only moves for a real sample.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load2 |-> r_v1)
        else $error("filter state advanced without a sample");

    // Once any sample passes, the tare offset is held from then on.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load1 |=> r_tare_taken)
        else $error("tare flag not set after first sample");

    // A full pipeline facing a stalled consumer must stall the producer.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && i_stall) |-> o_stall)
        else $error("input accepted into a full pipeline");

endmodule

`default_nettype wire

// ===== tb/wrench_tb_pkg.sv =====
`timescale 1ns / 1ps

package wrench_tb_pkg;

    import wrc_pkg::*;

    // One six-axis sample, field 0 is force x and field 5 is torque z.
    typedef logic [FIELD_COUNT-1:0][SAMPLE_WIDTH_DEF-1:0] t_wrench;

    localparam longint SAMPLE_MAX = 64'sd2147483647;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

    class wrench_scoreboard;

        logic [FACTOR_W-1:0] factor;
        longint deadband [FIELD_COUNT];
        longint tare [FIELD_COUNT];
        bit tare_taken;
        longint smoothed [FIELD_COUNT];
        t_wrench conditioned_q [$];
        int errors;

        function new();
            factor = FACTOR_RST;
            deadband[0] = longint'(DB_FX_RST);
            deadband[1] = longint'(DB_FY_RST);
            deadband[2] = longint'(DB_FZ_RST);
            deadband[3] = longint'(DB_TX_RST);
            deadband[4] = longint'(DB_TY_RST);
            deadband[5] = longint'(DB_TZ_RST);
            for (int i = 0; i < FIELD_COUNT; i++) begin
                tare[i] = 0;
                smoothed[i] = 0;
            end
            tare_taken = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_SMOOTHING) begin
                factor = data[FACTOR_W-1:0];
            end else if (idx >= REG_DB_FX && idx <= REG_DB_TZ) begin
                deadband[idx - REG_DB_FX] = longint'(data[DB_W-1:0]);
            end
        endfunction

        // Predicts the conditioned sample for an accepted raw sample.
        function void note_sample(t_wrench raw);
            longint x [FIELD_COUNT];
            longint a;
            longint v;
            longint d;
            longint q;
            longint r;
            longint y;
            longint mag;
            t_wrench res;
            for (int i = 0; i < FIELD_COUNT; i++) begin
                x[i] = longint'($signed(raw[i]));
            end
            if (x[0] == 0 || x[1] == 0) begin
                return;
            end
            if (!tare_taken) begin
                for (int i = 0; i < FIELD_COUNT; i++) begin
                    tare[i] = x[i];
                end
                tare_taken = 1'b1;
            end
            a = (factor > FACTOR_ONE) ? longint'(FACTOR_ONE) : longint'(factor);
            for (int i = 0; i < FIELD_COUNT; i++) begin
                v = x[i] - tare[i];
                if (v > SAMPLE_MAX) begin
                    v = SAMPLE_MAX;
                end else if (v < SAMPLE_MIN) begin
                    v = SAMPLE_MIN;
                end
                // Floor of a*d/2^16, split so that the product cannot overflow.
                d = v - smoothed[i];
                q = d >>> FRAC_W;
                r = d & 64'hFFFF;
                y = smoothed[i] + a * q + ((a * r) >>> FRAC_W);
                smoothed[i] = y;
                mag = (y < 0) ? -y : y;
                if (mag < deadband[i]) begin
                    y = 0;
                end
                res[i] = y[SAMPLE_WIDTH_DEF-1:0];
            end
            conditioned_q.push_back(res);
        endfunction

        function void check_result(t_wrench got);
            t_wrench want;
            if (conditioned_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected output transaction %h", $time, got);
                return;
            end
            want = conditioned_q.pop_front();
            for (int i = 0; i < FIELD_COUNT; i++) begin
                if (got[i] !== want[i]) begin
                    errors++;
                    $display("%0t: axis %0d mismatch: expected %h, actual %h",
                             $time, i, want[i], got[i]);
                end
            end
        endfunction

        function int pending();
            return conditioned_q.size();
        endfunction

    endclass

endpackage

// ===== tb/tb_six_axis_wrench_conditioner.sv =====
`timescale 1ns / 1ps

module tb_six_axis_wrench_conditioner
    import wrc_pkg::*, wrench_tb_pkg::*;
;

    // Quiet cycles that let the tare, filter and deadband stages run empty;
    // a rejected sample never enters the stages.
    localparam int PIPE_FLUSH = 8;

    // An index past the last register; writing it must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [CFG_DATA_W-1:0] DB_MAX = 31'h7FFF_FFFF;
    localparam logic [SAMPLE_WIDTH_DEF-1:0] AXIS_MIN = 32'h8000_0000;
    localparam logic [SAMPLE_WIDTH_DEF-1:0] AXIS_MAX = 32'h7FFF_FFFF;

    // The first sample that passes the force check becomes the tare. Force x,
    // force y and torque z are placed so that extreme inputs saturate low on
    // force x and torque z and high on force y, and force z has a tare of zero.
    localparam t_wrench TARE_SAMPLE = {32'h7FFF_FFFF, 32'hFFFE_DCBB, 32'h0001_2345,
                                       32'h0000_0000, 32'hC000_0000, 32'h4000_0000};

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} t_stall_mode;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]         i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]          i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    t_wrench                        drive_sample = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic signed [SAMPLE_WIDTH_DEF-1:0] o_force_x_out;
    logic signed [SAMPLE_WIDTH_DEF-1:0] o_force_y_out;
    logic signed [SAMPLE_WIDTH_DEF-1:0] o_force_z_out;
    logic signed [SAMPLE_WIDTH_DEF-1:0] o_torque_x_out;
    logic signed [SAMPLE_WIDTH_DEF-1:0] o_torque_y_out;
    logic signed [SAMPLE_WIDTH_DEF-1:0] o_torque_z_out;

    wrench_scoreboard sb;

    six_axis_wrench_conditioner DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_force_x_in   (drive_sample[0]),
        .i_force_y_in   (drive_sample[1]),
        .i_force_z_in   (drive_sample[2]),
        .i_torque_x_in  (drive_sample[3]),
        .i_torque_y_in  (drive_sample[4]),
        .i_torque_z_in  (drive_sample[5]),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_force_x_out  (o_force_x_out),
        .o_force_y_out  (o_force_y_out),
        .o_force_z_out  (o_force_z_out),
        .o_torque_x_out (o_torque_x_out),
        .o_torque_y_out (o_torque_y_out),
        .o_torque_z_out (o_torque_z_out)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // The receiver stalls on its own schedule. It switches at random between
    // never stalling, short random stalls, long stall runs and a strict
    // toggle, so output gaps land on every pipeline phase regardless of what
    // the sender is doing.
    t_stall_mode stall_mode = STALL_NONE;
    int          stall_left = 0;
    int          mode_left = 0;

    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left = $urandom_range(50, 300);
        end else begin
            mode_left--;
        end
        if (stall_left == 0) begin
            case (stall_mode)
                STALL_NONE: begin
                    i_stall = 1'b0;
                end
                STALL_LIGHT: begin
                    i_stall = ($urandom_range(0, 3) == 0);
                    stall_left = $urandom_range(0, 2);
                end
                STALL_HEAVY: begin
                    i_stall = ($urandom_range(0, 1) == 0);
                    stall_left = $urandom_range(1, 12);
                end
                default: begin
                    i_stall = ~i_stall;
                end
            endcase
        end else begin
            stall_left--;
        end
    end

    // An output transaction completes at a rising edge with valid high and
    // stall low; the payload is compared against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_result({o_torque_z_out, o_torque_y_out, o_torque_x_out,
                             o_force_z_out, o_force_y_out, o_force_x_out});
        end
    end

    // Presents one sample and holds it until the block takes it. Valid stays
    // high on return so that back-to-back calls stream without a bubble.
    task automatic send_sample(input t_wrench s);
        @(negedge i_clk);
        i_valid = 1'b1;
        drive_sample = s;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sb.note_sample(s);
    endtask

    task automatic pause_sender(input int cycles);
        repeat (cycles) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
    endtask

    // Stops the sender and waits for every predicted transaction, then lets
    // the stages run empty; a rejected sample never enters them.
    task automatic drain_pipeline();
        pause_sender(1);
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_FLUSH) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // Register writes happen only with the pipeline empty.
    task automatic apply_settings(input logic [CFG_DATA_W-1:0] factor,
                                  input logic [FIELD_COUNT-1:0][CFG_DATA_W-1:0] db);
        logic [CFG_INDEX_W-1:0] idx;
        drain_pipeline();
        write_reg(REG_SMOOTHING, factor);
        for (int i = 0; i < FIELD_COUNT; i++) begin
            idx = CFG_INDEX_W'(REG_DB_FX + i);
            write_reg(idx, db[i]);
        end
    endtask

    // A sample at a given distance from the tare, per axis. With the filter
    // in pass-through this puts an exact value on every output axis.
    function automatic t_wrench tare_plus(input int dfx, input int dfy, input int dfz,
                                          input int dtx, input int dty, input int dtz);
        t_wrench s;
        s[0] = TARE_SAMPLE[0] + dfx;
        s[1] = TARE_SAMPLE[1] + dfy;
        s[2] = TARE_SAMPLE[2] + dfz;
        s[3] = TARE_SAMPLE[3] + dtx;
        s[4] = TARE_SAMPLE[4] + dty;
        s[5] = TARE_SAMPLE[5] + dtz;
        return s;
    endfunction

    // Mixes full-range values, small values, the extremes and values close
    // to the tare so that outputs land on both sides of the deadbands.
    // Most samples pass the force check; a few carry a zero force x or y.
    function automatic t_wrench random_sample();
        t_wrench s;
        int      pick;
        for (int i = 0; i < FIELD_COUNT; i++) begin
            pick = $urandom_range(0, 9);
            if (pick <= 3) begin
                s[i] = $urandom;
            end else if (pick <= 5) begin
                s[i] = $urandom_range(0, 1 << 21) - (1 << 20);
            end else if (pick == 6) begin
                case ($urandom_range(0, 4))
                    0: s[i] = AXIS_MIN;
                    1: s[i] = AXIS_MAX;
                    2: s[i] = '0;
                    3: s[i] = '1;
                    default: s[i] = 32'd1;
                endcase
            end else begin
                s[i] = TARE_SAMPLE[i] + ($urandom_range(0, 1 << 18) - (1 << 17));
            end
        end
        if (s[0] == 0) s[0] = 32'd1;
        if (s[1] == 0) s[1] = 32'd1;
        if ($urandom_range(0, 11) == 0) begin
            case ($urandom_range(0, 2))
                0: s[0] = '0;
                1: s[1] = '0;
                default: s[1:0] = '0;
            endcase
        end
        return s;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_factor();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return 31'd1;
            2: return 31'd65535;
            3: return 31'd65536;
            4: return 31'd65537;
            5: return 31'd131071;
            6: return CFG_DATA_W'($urandom_range(0, 131071));
            default: return CFG_DATA_W'($urandom_range(1, 16384));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_deadband();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return DB_MAX;
            2, 3: return CFG_DATA_W'($urandom_range(0, 1 << 18));
            4: return CFG_DATA_W'($urandom_range(0, 1 << 24));
            default: return CFG_DATA_W'($urandom) & DB_MAX;
        endcase
    endfunction

    task automatic run_directed();
        t_wrench s;
        // Before the tare is taken, samples with a zero force x or force y
        // must be swallowed without producing anything.
        s = random_sample();
        s[0] = '0;
        s[1] = 32'h0000_0100;
        send_sample(s);
        s = random_sample();
        s[0] = 32'hFFFF_0000;
        s[1] = '0;
        send_sample(s);

        // The tare sample itself comes out as the filter response to zero.
        send_sample(TARE_SAMPLE);

        // All-minimum and all-maximum samples drive the tare subtraction into
        // saturation on force x, force y and torque z.
        send_sample({FIELD_COUNT{AXIS_MIN}});
        send_sample({FIELD_COUNT{AXIS_MAX}});
        send_sample({FIELD_COUNT{32'hFFFF_FFFF}});
        s = '0;
        s[0] = 32'd1;
        s[1] = '1;
        send_sample(s);

        // Reset deadbands: magnitude equal to the threshold passes, one below it is
        // zeroed but for torque z, which wraps and saturates; force z has no deadband.
        send_sample(tare_plus(65536, -65536, 1, 6554, -6554, -6554));
        send_sample(tare_plus(65535, -65535, -1, 6553, -6553, 6553));

        // Rejected samples after the tare leave the filter state alone.
        s = random_sample();
        s[1:0] = '0;
        send_sample(s);
        s = random_sample();
        s[1] = '0;
        send_sample(s);
        send_sample(random_sample());

        // Factor above one acts as one. With every deadband at its maximum,
        // only the most negative value (whose magnitude is exactly 2^31) and
        // the maximum itself get through.
        apply_settings(31'd131071, {FIELD_COUNT{DB_MAX}});
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        s = random_sample();
        s[0] = AXIS_MIN;
        s[1] = AXIS_MAX;
        send_sample(s);
        s[0] = AXIS_MAX;
        s[1] = AXIS_MIN;
        send_sample(s);

        // A zero factor freezes the filter: outputs repeat the held state.
        apply_settings('0, '0);
        send_sample(random_sample());
        send_sample(random_sample());

        // Fractional factors exercise the floor of the filter step on both
        // positive and negative differences.
        apply_settings(31'd32768, '0);
        send_sample(random_sample());
        send_sample(random_sample());
        send_sample(random_sample());
        apply_settings(31'd1, '0);
        send_sample(random_sample());
        send_sample(random_sample());
        apply_settings(31'd65535, '0);
        send_sample(random_sample());
        send_sample(random_sample());
    endtask

    // Random phases, each with its own register settings. The sender works
    // in bursts with gaps between them, and once per phase it holds off
    // until every outstanding transaction has come back.
    task automatic run_random();
        logic [FIELD_COUNT-1:0][CFG_DATA_W-1:0] db;
        t_wrench s;
        int      sent;
        int      burst;
        int      gap;
        bit      drained;
        for (int phase = 0; phase < 6; phase++) begin
            for (int i = 0; i < FIELD_COUNT; i++) begin
                db[i] = random_deadband();
            end
            apply_settings(random_factor(), db);
            sent = 0;
            drained = 1'b0;
            while (sent < 75) begin
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(32, 80)
                                                    : $urandom_range(1, 16);
                for (int k = 0; k < burst && sent < 75; k++) begin
                    s = random_sample();
                    send_sample(s);
                    if (s[0] != 0 && s[1] != 0) begin
                        sent++;
                    end
                end
                gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                pause_sender(gap);
                if (!drained && sent >= 40) begin
                    drain_pipeline();
                    drained = 1'b1;
                end
            end
        end
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        run_directed();
        run_random();
        drain_pipeline();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_six_axis_wrench_conditioner passed");
        end else begin
            $display("tb_six_axis_wrench_conditioner failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run of this stimulus.
    initial begin
        #5_000_000;
        $display("tb_six_axis_wrench_conditioner failed");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/wrc_pkg.sv
rtl/wrc_lane.sv
rtl/wrc_ctrl.sv
rtl/six_axis_wrench_conditioner.sv
tb/wrench_tb_pkg.sv
tb/tb_six_axis_wrench_conditioner.sv
